>>> rtl/core/dftx_pkg.sv
// Shared types and constants for the DShot frame transmitter.
// No dependencies; imported by every module of the block.
package dftx_pkg;

	localparam int FRAME_BITS = 16;
	localparam int VAL_BITS   = 11;

	localparam logic [VAL_BITS-1:0] RAW_MAX      = 11'd2047;
	localparam logic [VAL_BITS-1:0] SCALE_MIN    = 11'd48;
	localparam logic [9:0]          SCALE_IN_MAX = 10'd1000;

	localparam logic [15:0] PERIOD_RST    = 16'd800;
	localparam logic [15:0] ONE_HIGH_RST  = 16'd600;
	localparam logic [15:0] ZERO_HIGH_RST = 16'd300;

	localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
	localparam logic [1:0] REG_ONE_HIGH   = 2'd1;
	localparam logic [1:0] REG_ZERO_HIGH  = 2'd2;
	localparam logic [1:0] REG_INPUT_MODE = 2'd3;

	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_SEND = 1'b1
	} req_t;

	typedef enum logic {
		MODE_RAW    = 1'b0,
		MODE_SCALED = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		STAT_TICK   = 2'd0,
		STAT_ACCEPT = 2'd1,
		STAT_REJECT = 2'd2
	} status_t;

	typedef struct packed {
		req_t               req_type;
		logic signed [15:0] command_value;
		logic               telemetry_request;
	} send_word_t;

	typedef struct packed {
		logic        pin_level;
		logic        busy_res;
		status_t     status;
		logic [15:0] frame_word;
	} res_word_t;

	typedef struct packed {
		logic [15:0] bit_period_ticks;
		logic [15:0] one_high_ticks;
		logic [15:0] zero_high_ticks;
		mode_t       input_mode;
	} cfg_t;

endpackage

>>> rtl/core/dshot_frame_transmitter_top.sv
// DShot frame transmitter top: configuration registers, encoder, sequencer,
// result register. Depends on dftx_pkg, dftx_encode and dftx_seq.
//
//   channel  direction  handshake            payload
//   send     in         send_valid/send_stall send_word_t send_word
//   res      out        res_valid/res_stall   res_word_t  res_word
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One word accepted per cycle while send_stall is low; its result word is formed
// combinationally and registered in the result register. A held, stalled result
// stalls the send side, a busy sequencer does not: send_stall is high only while a held result is itself stalled.
// Reset clears the line state to idle and loads the default timing.
module dshot_frame_transmitter_top import dftx_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        send_valid,
	output logic        send_stall,
	input  send_word_t  send_word,
	output logic        res_valid,
	input  logic        res_stall,
	output res_word_t   res_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t      cfg_q;
	logic      res_valid_q;
	res_word_t res_word_q;
	logic      accept;
	logic [15:0] frame;
	res_word_t res_d;

	assign cfg_ready  = 1'b1;
	assign send_stall = res_valid_q && res_stall;
	assign accept     = send_valid && !send_stall;
	assign res_valid  = res_valid_q;
	assign res_word   = res_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_period_ticks <= PERIOD_RST;
			cfg_q.one_high_ticks   <= ONE_HIGH_RST;
			cfg_q.zero_high_ticks  <= ZERO_HIGH_RST;
			cfg_q.input_mode       <= MODE_RAW;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BIT_PERIOD: cfg_q.bit_period_ticks <= cfg_data;
				REG_ONE_HIGH:   cfg_q.one_high_ticks   <= cfg_data;
				REG_ZERO_HIGH:  cfg_q.zero_high_ticks  <= cfg_data;
				REG_INPUT_MODE: cfg_q.input_mode       <= mode_t'(cfg_data[0]);
				default: begin
				end
			endcase
		end
	end

	dftx_encode u_encode (
		.input_mode        (cfg_q.input_mode),
		.command_value     (send_word.command_value),
		.telemetry_request (send_word.telemetry_request),
		.frame             (frame)
	);

	dftx_seq #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (send_word.req_type),
		.frame    (frame),
		.cfg      (cfg_q),
		.res      (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_word_q <= res_d;
		end
	end

endmodule

>>> rtl/core/dftx_encode.sv
// Frame encoder: command clamp or scale, telemetry bit, nibble checksum.
// Depends on dftx_pkg.
module dftx_encode import dftx_pkg::*; (
	input  mode_t              input_mode,
	input  logic signed [15:0] command_value,
	input  logic               telemetry_request,
	output logic [15:0]        frame
);

	localparam logic signed [15:0] SCALE_IN_MAX_S = 16'sd1000;

	logic [15:0]         raw;
	logic [9:0]          v_clamp;
	logic [9:0]          v_less;
	logic [VAL_BITS-1:0] val;
	logic                tel;
	logic [11:0]         pkt;
	logic [3:0]          crc;

	// (v-1)*1999/999 equals 2*(v-1) plus one only at v = 1000
	always_comb begin
		raw     = command_value;
		v_clamp = (command_value > SCALE_IN_MAX_S) ? SCALE_IN_MAX : command_value[9:0];
		v_less  = v_clamp - 10'd1;
		if (input_mode == MODE_SCALED) begin
			tel = 1'b0;
			if (command_value <= 16'sd0) begin
				val = '0;
			end else begin
				val = SCALE_MIN + {v_less, 1'b0}
					+ {{(VAL_BITS-1){1'b0}}, (v_clamp == SCALE_IN_MAX)};
			end
		end else begin
			tel = telemetry_request;
			val = (raw > {5'd0, RAW_MAX}) ? RAW_MAX : raw[VAL_BITS-1:0];
		end
		pkt   = {val, tel};
		crc   = pkt[3:0] ^ pkt[7:4] ^ pkt[11:8];
		frame = {pkt, crc};
	end

endmodule

>>> rtl/core/dftx_seq.sv
// Line sequencer: frame shift register, tick and bit counters, busy flag.
// Depends on dftx_pkg; forms the result word for each accepted word.
module dftx_seq import dftx_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  req_t       req_type,
	input  logic [15:0] frame,
	input  cfg_t       cfg,
	output res_word_t  res
);

	localparam int EW = (COUNT_WIDTH + 1 > 17) ? COUNT_WIDTH + 1 : 17;
	localparam logic [EW-1:0] CAP = {{(EW-1){1'b0}}, 1'b1} << COUNT_WIDTH;

	logic [15:0]            frame_shift_q;
	logic [COUNT_WIDTH-1:0] tick_count_q;
	logic [4:0]             bit_index_q;
	logic                   busy_q;

	logic [15:0]            frame_shift_d;
	logic [COUNT_WIDTH-1:0] tick_count_d;
	logic [4:0]             bit_index_d;
	logic                   busy_d;

	logic [EW-1:0] per_ext;
	logic [EW-1:0] per_eff;
	logic [EW-1:0] tick_ext;
	logic [EW-1:0] tick_inc;
	logic [EW-1:0] high_ext;
	logic          level;
	status_t       status;

	always_comb begin
		per_ext  = EW'(cfg.bit_period_ticks);
		per_eff  = per_ext;
		if (per_ext == '0) begin
			per_eff = EW'(1);
		end else if (per_ext > CAP) begin
			per_eff = CAP;
		end
		tick_ext = EW'(tick_count_q);
		tick_inc = tick_ext + EW'(1);
		high_ext = frame_shift_q[15] ? EW'(cfg.one_high_ticks) : EW'(cfg.zero_high_ticks);
		level    = busy_q && (bit_index_q < 5'(FRAME_BITS)) && (tick_ext < high_ext);

		frame_shift_d = frame_shift_q;
		tick_count_d  = tick_count_q;
		bit_index_d   = bit_index_q;
		busy_d        = busy_q;
		status        = STAT_TICK;

		case (req_type)
			REQ_SEND: begin
				if (busy_q) begin
					status = STAT_REJECT;
				end else begin
					status        = STAT_ACCEPT;
					frame_shift_d = frame;
					tick_count_d  = '0;
					bit_index_d   = '0;
					busy_d        = 1'b1;
				end
			end
			REQ_TICK: begin
				if (busy_q) begin
					if (tick_inc >= per_eff) begin
						tick_count_d  = '0;
						frame_shift_d = {frame_shift_q[14:0], 1'b0};
						if (bit_index_q >= 5'(FRAME_BITS)) begin
							bit_index_d = '0;
							busy_d      = 1'b0;
						end else begin
							bit_index_d = bit_index_q + 5'd1;
						end
					end else begin
						tick_count_d = tick_inc[COUNT_WIDTH-1:0];
					end
				end
			end
			default: begin
				status = STAT_TICK;
			end
		endcase

		res.pin_level  = level;
		res.busy_res   = busy_d;
		res.status     = status;
		res.frame_word = (status == STAT_ACCEPT) ? frame : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_shift_q <= '0;
			tick_count_q  <= '0;
			bit_index_q   <= '0;
			busy_q        <= 1'b0;
		end else if (accept) begin
			frame_shift_q <= frame_shift_d;
			tick_count_q  <= tick_count_d;
			bit_index_q   <= bit_index_d;
			busy_q        <= busy_d;
		end
	end

endmodule

>>> rtl/core/dftx_checker.sv
// Port checker for the DShot frame transmitter, bound to the top level.
// Depends on dftx_pkg.
module dftx_checker import dftx_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        send_stall,
	input logic        res_valid,
	input logic        res_stall,
	input res_word_t   res_word
);

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		send_stall |-> res_valid && res_stall)
		else $error("send stalled without a held result word");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_word))
		else $error("stalled result word changed");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.status == STAT_ACCEPT |-> res_word.busy_res && !res_word.pin_level)
		else $error("accepted frame without busy or with line high");

	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.status == STAT_REJECT |-> res_word.busy_res
			&& res_word.frame_word == 16'd0)
		else $error("rejected word carries a frame or shows idle");

	a_tick_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.status == STAT_TICK |-> res_word.frame_word == 16'd0)
		else $error("tick word carries a frame");

endmodule

bind dshot_frame_transmitter_top dftx_checker u_dftx_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.send_stall (send_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_word   (res_word)
);

>>> tb/tb_dshot_frame_transmitter_top.sv
// Self-checking bench for dshot_frame_transmitter_top: queued send and tick words,
// random gaps and result stalls, and an in-bench line model checked word by word.
// Depends on dftx_pkg and the transmitter RTL only.
module tb_dshot_frame_transmitter_top;
	import dftx_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 80;
	localparam int PHASE_WORDS = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        send_valid = 1'b0;
	logic        send_stall;
	send_word_t  send_word = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_word_t   res_word;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_BIT_PERIOD;
	logic [15:0] cfg_data = '0;

	dshot_frame_transmitter_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.send_valid (send_valid),
		.send_stall (send_stall),
		.send_word  (send_word),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_word   (res_word),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// line model: timing registers and sequencer state
	logic [15:0] t_period    = PERIOD_RST;
	logic [15:0] t_one_high  = ONE_HIGH_RST;
	logic [15:0] t_zero_high = ZERO_HIGH_RST;
	mode_t       t_mode      = MODE_RAW;
	logic [15:0] line_shift  = '0;
	int          line_tick   = 0;
	logic [4:0]  line_bit    = '0;
	logic        line_busy   = 1'b0;

	send_word_t pending_words[$];
	res_word_t  expected_line_q[$];
	res_word_t  want;

	bit idle_on = 1'b0;
	int send_gap, res_hold, quiet_cycles;
	int errors, results_seen, words_queued, reg_writes, settings;
	int n_frames, n_refused, n_ticks;

	function automatic int eff_period();
		return (t_period == 0) ? 1 : int'(t_period);
	endfunction

	function automatic int frame_ticks();
		return (FRAME_BITS + 1) * eff_period();
	endfunction

	function automatic res_word_t predict_line_step(send_word_t w);
		res_word_t   r;
		logic [15:0] hi;
		logic [15:0] raw;
		logic [10:0] val;
		logic        tel;
		logic [11:0] pkt;
		int          s, v;
		r = '0;
		r.status = STAT_TICK;
		if (line_busy && line_bit < FRAME_BITS) begin
			hi = line_shift[15] ? t_one_high : t_zero_high;
			r.pin_level = (line_tick < int'(hi));
		end
		if (w.req_type == REQ_SEND) begin
			if (line_busy) begin
				r.status = STAT_REJECT;
			end else begin
				if (t_mode == MODE_SCALED) begin
					s = int'(w.command_value);
					if (s <= 0) begin
						val = '0;
					end else begin
						v = (s > int'(SCALE_IN_MAX)) ? int'(SCALE_IN_MAX) : s;
						val = 11'(int'(SCALE_MIN) + (v - 1)
							* (int'(RAW_MAX) - int'(SCALE_MIN))
							/ (int'(SCALE_IN_MAX) - 1));
					end
					tel = 1'b0;
				end else begin
					raw = w.command_value;
					v = int'(raw);
					val = (v > int'(RAW_MAX)) ? RAW_MAX : 11'(v);
					tel = w.telemetry_request;
				end
				pkt = {val, tel};
				r.frame_word = {pkt, pkt[3:0] ^ pkt[7:4] ^ pkt[11:8]};
				line_shift = r.frame_word;
				line_tick = 0;
				line_bit = '0;
				line_busy = 1'b1;
				r.status = STAT_ACCEPT;
			end
		end else if (line_busy) begin
			if (line_tick + 1 >= eff_period()) begin
				line_tick = 0;
				line_shift = line_shift << 1;
				if (line_bit >= FRAME_BITS) begin
					line_bit = '0;
					line_busy = 1'b0;
				end else begin
					line_bit = line_bit + 1'b1;
				end
			end else begin
				line_tick = line_tick + 1;
			end
		end
		r.busy_res = line_busy;
		return r;
	endfunction

	// send side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_valid <= 1'b0;
			send_word <= '0;
			send_gap = 0;
		end else begin
			if (send_valid && !send_stall)
				expected_line_q.push_back(predict_line_step(send_word));
			if (!send_valid || !send_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					send_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					send_valid <= 1'b1;
					send_word <= pending_words.pop_front();
					send_gap = idle_on ? $urandom_range(0, 9) : 0;
				end else begin
					send_valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			res_hold = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_line_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word %h", res_word);
				end else begin
					want = expected_line_q.pop_front();
					if (res_word.pin_level !== want.pin_level ||
						res_word.busy_res !== want.busy_res ||
						res_word.status !== want.status ||
						res_word.frame_word !== want.frame_word) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: want pin=%0b busy=%0b status=%0d frame=%h",
								want.pin_level, want.busy_res, want.status, want.frame_word,
								", got pin=%0b busy=%0b status=%0d frame=%h",
								res_word.pin_level, res_word.busy_res, res_word.status,
								res_word.frame_word);
					end
				end
				case (res_word.status)
					STAT_ACCEPT: n_frames++;
					STAT_REJECT: n_refused++;
					default:     n_ticks++;
				endcase
				results_seen++;
				res_hold = idle_on ? $urandom_range(0, 9) : 0;
				if (results_seen % 5000 == 300)
					res_hold = LONG_HOLD;
			end
			if (res_hold > 0) begin
				res_stall <= 1'b1;
				res_hold--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (send_valid && !send_stall) || (res_valid && !res_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[dshot_frame_transmitter_top] ERROR");
				$finish;
			end
		end
	end

	task automatic push_item(input req_t req, input logic [15:0] cmd, input logic tel);
		send_word_t w;
		w.req_type = req;
		w.command_value = cmd;
		w.telemetry_request = tel;
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic push_ticks(input int n);
		repeat (n) push_item(REQ_TICK, 16'($urandom), 1'($urandom));
	endtask

	// send a frame, tick n times, optionally try a second send part way through
	task automatic send_frame(input logic [15:0] cmd, input logic tel, input int n,
		input int refuse_at);
		push_item(REQ_SEND, cmd, tel);
		if (refuse_at >= 0 && refuse_at <= n) begin
			push_ticks(refuse_at);
			push_item(REQ_SEND, 16'($urandom), 1'($urandom));
			push_ticks(n - refuse_at);
		end else begin
			push_ticks(n);
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || send_valid || expected_line_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_out();
		while (line_busy) begin
			push_ticks(frame_ticks());
			wait_drained();
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			REG_BIT_PERIOD: t_period = val;
			REG_ONE_HIGH:   t_one_high = val;
			REG_ZERO_HIGH:  t_zero_high = val;
			REG_INPUT_MODE: t_mode = mode_t'(val[0]);
			default: ;
		endcase
	endtask

	// load new timing; a frame still on the line runs out before the writes when the old
	// period is no longer, else after them, so under whichever of the two periods is shorter
	task automatic set_timing(input logic [15:0] per, input logic [15:0] one,
		input logic [15:0] zero, input mode_t mode);
		int new_per;
		new_per = (per == 0) ? 1 : int'(per);
		wait_drained();
		if (eff_period() <= new_per)
			run_out();
		write_reg(REG_BIT_PERIOD, per);
		write_reg(REG_ONE_HIGH, one);
		write_reg(REG_ZERO_HIGH, zero);
		write_reg(REG_INPUT_MODE, {15'b0, mode});
		run_out();
		settings++;
	endtask

	initial begin : stimulus
		logic [15:0] cmd, per, one, zero;
		int          start, n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// default timing: idle tick, start of a frame, refused send mid-frame
		push_ticks(1);
		send_frame(16'h07FF, 1'b1, 60, 5);

		set_timing(16'd3, 16'd2, 16'd1, MODE_RAW);
		send_frame(16'h0000, 1'b0, frame_ticks(), -1);
		send_frame(16'd2048, 1'b1, frame_ticks(), -1);
		send_frame(16'h8000, 1'b0, frame_ticks(), -1);
		send_frame(16'hFFFF, 1'b1, frame_ticks(), -1);
		send_frame(16'h7FFF, 1'b0, frame_ticks(), -1);
		send_frame(16'd1, 1'b1, frame_ticks(), 0);

		set_timing(16'd0, 16'd1, 16'd0, MODE_SCALED);
		send_frame(16'd0, 1'b1, frame_ticks(), -1);
		send_frame(16'hFFFF, 1'b1, frame_ticks(), -1);
		send_frame(16'h8000, 1'b0, frame_ticks(), -1);
		send_frame(16'd1, 1'b1, frame_ticks(), -1);
		send_frame(16'd1000, 1'b1, frame_ticks(), -1);
		send_frame(16'd1001, 1'b0, frame_ticks(), -1);
		send_frame(16'h7FFF, 1'b1, frame_ticks(), -1);
		send_frame(16'd500, 1'b0, frame_ticks(), -1);

		set_timing(16'd1, 16'd0, 16'hFFFF, MODE_RAW);
		send_frame(16'h0555, 1'b0, frame_ticks(), -1);
		send_frame(16'h02AA, 1'b1, frame_ticks(), -1);

		set_timing(16'd5, 16'd5, 16'd4, MODE_SCALED);
		send_frame(16'd777, 1'b1, frame_ticks() + 3, -1);

		// random timing settings, mostly whole frames, some cut short or noise
		repeat (8) begin
			per = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3))
				: 16'($urandom_range(4, 12));
			case ($urandom_range(0, 5))
				0:       one = 16'd0;
				1:       one = 16'hFFFF;
				default: one = 16'($urandom_range(0, per + 1));
			endcase
			case ($urandom_range(0, 5))
				0:       zero = 16'd0;
				1:       zero = 16'hFFFF;
				default: zero = 16'($urandom_range(0, per + 1));
			endcase
			set_timing(per, one, zero, mode_t'($urandom_range(0, 1)));
			idle_on = ($urandom_range(0, 3) != 0);
			start = words_queued;
			while (words_queued - start < PHASE_WORDS) begin
				case ($urandom_range(0, 4))
					0:       cmd = 16'($urandom);
					1:       cmd = 16'($urandom_range(0, 2047));
					2:       cmd = 16'($urandom_range(2040, 2055));
					3:       cmd = 16'($urandom_range(0, 1006)) - 16'd3;
					default: cmd = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
				endcase
				if ($urandom_range(0, 99) < 80) begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, frame_ticks())
						: frame_ticks() + $urandom_range(0, 3);
					send_frame(cmd, 1'($urandom), n,
						($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : -1);
				end else begin
					repeat ($urandom_range(1, 4))
						push_item(req_t'($urandom_range(0, 1)), 16'($urandom), 1'($urandom));
				end
			end
		end

		// longest period and high time: only the start of the frame is seen
		set_timing(16'hFFFF, 16'hFFFF, 16'd0, MODE_RAW);
		idle_on = 1'b1;
		send_frame(16'h05A5, 1'b1, 300, 150);

		wait_drained();
		repeat (4) @(posedge clk);
		errors += expected_line_q.size();
		$display("covered %0d frames, %0d refused sends and %0d ticks",
			n_frames, n_refused, n_ticks);
		$display("over %0d timing settings (%0d register writes)", settings + 1, reg_writes);
		if (errors == 0) begin
			$display("[dshot_frame_transmitter_top] OK");
		end else begin
			$display("[dshot_frame_transmitter_top] ERROR");
		end
		$finish;
	end

endmodule

>>> dshot_frame_transmitter_top.f
rtl/core/dftx_pkg.sv
rtl/core/dftx_encode.sv
rtl/core/dftx_seq.sv
rtl/core/dshot_frame_transmitter_top.sv
rtl/core/dftx_checker.sv
tb/tb_dshot_frame_transmitter_top.sv
